/* hw/rtl/tsma_pkg.sv */
`timescale 1ns / 1ps

package tsma_pkg;

  // Default number of values that each set can hold.
  localparam int MAX_ITEMS_DEFAULT = 256;

  // Field widths of a request and a result.
  localparam int VALUE_W = 32;
  localparam int MED_W   = 33;
  localparam int AVG_W   = 34;

  // Set numbers.
  localparam logic SET_FIRST  = 1'b0;
  localparam logic SET_SECOND = 1'b1;

endpackage

/* hw/rtl/two_set_median_average_top.sv */
`timescale 1ns / 1ps

// Flow: a request to a full set drops its value; a request to an empty set writes it in
//   ST_INS; otherwise ST_CMP moves each larger stored value up one place to make room.
//   A request that ends its set then passes through ST_MED_A, ST_MED_B, ST_MED_C and
//   ST_EMIT, which waits while the result is stalled.
// Requests: one at a time; in_stall holds off the next request until the block is idle.
// Reset: counts, overflow and finished flags clear at once; the memory is not cleared.
module two_set_median_average_top
  import tsma_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // Request channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                     set_id,
  input  logic                     last,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     which_set,
  output logic signed [MED_W-1:0]  median_doubled,
  output logic                     average_valid,
  output logic signed [AVG_W-1:0]  average_quadrupled,
  output logic                     overflow
);

  // Address width of one set's region, and width of a count that can reach MAX_ITEMS.
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int DEPTH = 2 * (2 ** AW);

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a request
    ST_INS,    // place the value at pos, or start the scan downward
    ST_CMP,    // compare the entry below pos with the value; shift it up if larger, else place the value
    ST_MED_A,  // read the upper middle entry
    ST_MED_B,  // read the lower middle entry
    ST_MED_C,  // form the doubled median
    ST_EMIT    // load the result register and update the finished medians
  } state_t;

  state_t state;

  // Both sets share one memory; the set number is the top address bit.
  logic [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata;

  logic              we;
  logic [AW:0]       waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW:0]       raddr;

  // Captured request.
  logic signed [VALUE_W-1:0] val_r;
  logic                      set_r;
  logic                      last_r;
  logic [AW-1:0]             pos;

  // Per-set bookkeeping.
  logic [CW-1:0] cnt [2];
  logic          ovf [2];
  logic signed [MED_W-1:0] fin_med [2];
  logic          fin_flag [2];

  // Median working registers.
  logic signed [VALUE_W-1:0] hi;
  logic signed [MED_W-1:0]   med_r;

  logic [AW-1:0] pos_m1;
  logic [AW-1:0] pos_m2;
  logic [CW-1:0] half;
  logic [AW-1:0] mid;
  logic [AW-1:0] mid_m1;
  logic [CW-1:0] cur_cnt;
  logic          out_free;
  logic          emit;
  logic          both_done;
  logic signed [AVG_W-1:0] avg_sum;

  assign in_stall = (state != ST_IDLE);

  assign pos_m1  = pos - 1'b1;
  assign pos_m2  = pos_m1 - 1'b1;
  assign cur_cnt = cnt[set_r];
  assign half    = cur_cnt >> 1;
  assign mid     = half[AW-1:0];
  assign mid_m1  = mid - 1'b1;

  assign out_free  = !out_valid || !out_stall;
  assign emit      = (state == ST_EMIT) && out_free;
  assign both_done = fin_flag[~set_r];
  assign avg_sum   = {med_r[MED_W-1], med_r} +
                     {fin_med[~set_r][MED_W-1], fin_med[~set_r]};

  // Memory port control. In the scan, the entry at pos is written while the entry two places
  // below pos is read for the next compare, so a value moves up by one place every cycle.
  always_comb begin
    we    = 1'b0;
    waddr = {set_r, pos};
    wdata = val_r;
    raddr = {set_r, pos_m1};
    unique case (state)
      ST_INS: begin
        if (pos == '0) begin
          we = 1'b1;
        end
      end
      ST_CMP: begin
        we    = 1'b1;
        raddr = {set_r, pos_m2};
        if (rdata > val_r) begin
          wdata = rdata;
        end
      end
      ST_MED_A: raddr = {set_r, mid};
      ST_MED_B: raddr = {set_r, mid_m1};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt[0]      <= '0;
      cnt[1]      <= '0;
      ovf[0]      <= 1'b0;
      ovf[1]      <= 1'b0;
      fin_flag[0] <= 1'b0;
      fin_flag[1] <= 1'b0;
      fin_med[0]  <= '0;
      fin_med[1]  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            val_r  <= value;
            set_r  <= set_id;
            last_r <= last;
            pos    <= cnt[set_id][AW-1:0];
            if (cnt[set_id] == CW'(MAX_ITEMS)) begin
              // A full set drops the value; a last flag still ends the set.
              ovf[set_id] <= 1'b1;
              state       <= last ? ST_MED_A : ST_IDLE;
            end else begin
              state <= ST_INS;
            end
          end
        end
        ST_INS: begin
          if (pos == '0) begin
            cnt[set_r] <= cur_cnt + 1'b1;
            state      <= last_r ? ST_MED_A : ST_IDLE;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (rdata > val_r) begin
            pos   <= pos_m1;
            state <= (pos == AW'(1)) ? ST_INS : ST_CMP;
          end else begin
            cnt[set_r] <= cur_cnt + 1'b1;
            state      <= last_r ? ST_MED_A : ST_IDLE;
          end
        end
        ST_MED_A: state <= ST_MED_B;
        ST_MED_B: begin
          hi    <= rdata;
          state <= ST_MED_C;
        end
        ST_MED_C: begin
          if (cur_cnt[0]) begin
            med_r <= {hi, 1'b0};
          end else begin
            med_r <= {hi[VALUE_W-1], hi} + {rdata[VALUE_W-1], rdata};
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            which_set      <= set_r;
            median_doubled <= med_r;
            overflow       <= ovf[set_r];
            cnt[set_r]     <= '0;
            ovf[set_r]     <= 1'b0;
            fin_med[set_r] <= med_r;
            if (both_done) begin
              // Both sets have ended: report the sum of the doubled medians and start over.
              average_valid      <= 1'b1;
              average_quadrupled <= avg_sum;
              fin_flag[0]        <= 1'b0;
              fin_flag[1]        <= 1'b0;
            end else begin
              average_valid      <= 1'b0;
              average_quadrupled <= '0;
              fin_flag[set_r]    <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // A set never holds more values than its capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt[0] <= CW'(MAX_ITEMS)) && (cnt[1] <= CW'(MAX_ITEMS)))
    else $error("set count beyond capacity");

  // A median is only formed for a request that ends its set.
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> last_r)
    else $error("median formed for a request without last");

  // Reporting the average clears both finished flags.
  a_avg_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && both_done) |=> (!fin_flag[0] && !fin_flag[1] && out_valid && average_valid))
    else $error("finished flags survive an average");

  // The memory is never written while the block waits for a request.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !we)
    else $error("memory write while idle");
`endif

endmodule

/* sim/two_set_median_average_top_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the two-set median and average block. Requests go in through
// a single task that records the expected result of each set-ending request. A separate
// checker process compares each accepted result against the oldest recorded expectation.
module two_set_median_average_top_tb;
  import tsma_pkg::*;

  // Each set's storage depth, matching the default build of the block.
  localparam int CAPACITY = MAX_ITEMS_DEFAULT;
  // Longer than the slowest request, so this covers the drain at the end.
  localparam int DRAIN_CYCLES = CAPACITY + 50;
  // Length of the long receiver hold-off used to back the block up.
  localparam int HOLD_CYCLES = 1500;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // One expected median result, laid out like the result ports.
  typedef struct packed {
    logic                    which;
    logic signed [MED_W-1:0] median;
    logic                    avg_valid;
    logic signed [AVG_W-1:0] avg;
    logic                    dropped;
  } median_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // All block inputs start at known values.
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      set_id = SET_FIRST;
  logic                      last = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      which_set;
  logic signed [MED_W-1:0]   median_doubled;
  logic                      average_valid;
  logic signed [AVG_W-1:0]   average_quadrupled;
  logic                      overflow;

  // Idle rates, as a percentage of cycles, for the request side and the result side.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The hold-off process raises hold_active for one long hold-off when asked.
  logic hold_req = 1'b0;
  logic hold_active = 1'b0;

  // Our own copy of the block's state: each set's values kept in ascending order, the
  // number held, the dropped-value flags and the medians of sets that have finished.
  int                      sorted_vals[2][CAPACITY];
  int unsigned             sorted_count[2] = '{0, 0};
  logic                    set_dropped[2] = '{1'b0, 1'b0};
  logic signed [MED_W-1:0] done_median[2] = '{'0, '0};
  logic                    done_flag[2] = '{1'b0, 1'b0};

  // Expected results, oldest first.
  median_result_t pending_medians[$];
  int mismatch_count = 0;

  two_set_median_average_top DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .value             (value),
    .set_id            (set_id),
    .last              (last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .which_set         (which_set),
    .median_doubled    (median_doubled),
    .average_valid     (average_valid),
    .average_quadrupled(average_quadrupled),
    .overflow          (overflow)
  );

  initial forever #5 clk = ~clk;

  // Hard stop in case the block hangs. The slowest legal run is well under a tenth of this.
  initial begin
    #100_000_000;
    $display("two_set_median_average_top: mismatch");
    $finish;
  end

  // Prints one line per mismatch and keeps the count that decides the final verdict.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("ERROR %0t ns: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  // Applies one accepted request to our copy of the state. A value goes into its set by
  // ordered insertion unless the set is already full, in which case it is dropped and
  // flagged. A request marked last closes its set even when its own value was dropped, and
  // then one result is expected: the doubled median, plus the summed medians once both
  // sets have finished since the last average.
  task automatic predict_median(input logic signed [VALUE_W-1:0] v, input logic sid,
                                input logic lst);
    int unsigned n;
    int pos;
    longint med;
    median_result_t r;
    n = sorted_count[sid];
    if (n >= CAPACITY) begin
      set_dropped[sid] = 1'b1;
    end else begin
      pos = n;
      while (pos > 0 && sorted_vals[sid][pos-1] > int'(v)) begin
        sorted_vals[sid][pos] = sorted_vals[sid][pos-1];
        pos--;
      end
      sorted_vals[sid][pos] = v;
      sorted_count[sid] = n + 1;
    end
    if (lst) begin
      n = sorted_count[sid];
      // Odd count: twice the middle value. Even count: sum of the two middle values.
      if (n % 2)
        med = 2 * longint'(sorted_vals[sid][n/2]);
      else
        med = longint'(sorted_vals[sid][n/2]) + longint'(sorted_vals[sid][n/2-1]);
      r.which = sid;
      r.median = med[MED_W-1:0];
      r.dropped = set_dropped[sid];
      r.avg_valid = 1'b0;
      r.avg = '0;
      // The set empties at once for its next round.
      sorted_count[sid] = 0;
      set_dropped[sid] = 1'b0;
      // A second finish of the same set simply replaces its remembered median.
      done_median[sid] = r.median;
      done_flag[sid] = 1'b1;
      if (done_flag[0] && done_flag[1]) begin
        r.avg_valid = 1'b1;
        r.avg = AVG_W'(done_median[0]) + AVG_W'(done_median[1]);
        done_flag[0] = 1'b0;
        done_flag[1] = 1'b0;
      end
      pending_medians.push_back(r);
    end
  endtask

  // Offers one request and returns at the edge where it is taken. Valid stays high on
  // return, so back-to-back requests never drop it, and the payload holds while stalled.
  task automatic send_request(input logic signed [VALUE_W-1:0] v, input logic sid,
                              input logic lst);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    set_id <= sid;
    last <= lst;
    do @(posedge clk); while (in_stall);
    predict_median(v, sid, lst);
  endtask

  // Values lean toward the extremes and toward a narrow band near zero, where equal
  // values and ties in the ordering are common.
  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2, 3, 4: return VALUE_W'($urandom_range(40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Most sets are short so the run stays fast; a few are long, and a rare one overflows.
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 80)
      return $urandom_range(1, 6);
    else if (r < 97)
      return $urandom_range(7, 40);
    else
      return $urandom_range(41, CAPACITY + 4);
  endfunction

  // Result side: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    median_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        report_mismatch("result with nothing pending, which_set", which_set, 0);
      end else begin
        want = pending_medians.pop_front();
        if (which_set !== want.which)
          report_mismatch("which_set", which_set, want.which);
        if (median_doubled !== want.median)
          report_mismatch("median_doubled", median_doubled, want.median);
        if (average_valid !== want.avg_valid)
          report_mismatch("average_valid", average_valid, want.avg_valid);
        if (average_quadrupled !== want.avg)
          report_mismatch("average_quadrupled", average_quadrupled, want.avg);
        if (overflow !== want.dropped)
          report_mismatch("overflow", overflow, want.dropped);
      end
    end
  end

  // Result side: random stalls at the current rate, or a solid stall during a hold-off.
  always @(posedge clk) begin
    out_stall <= hold_active || (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Counts out one long hold-off on the result side each time one is asked for.
  initial forever begin
    @(posedge clk);
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Short hand-picked sequences: single-value sets at both extremes, an even set whose
  // middle values sum past 32 bits, a set finishing twice before the other one does,
  // values arriving in descending order so every insertion shifts the whole set,
  // interleaved sets, and sets of repeated values.
  task automatic test_directed_cases();
    send_request(VALUE_MAX, SET_FIRST, 1'b1);
    send_request(VALUE_MIN, SET_SECOND, 1'b1);
    send_request(VALUE_MIN, SET_FIRST, 1'b0);
    send_request(VALUE_MAX, SET_FIRST, 1'b1);
    send_request(5, SET_FIRST, 1'b0);
    send_request(3, SET_FIRST, 1'b0);
    send_request(1, SET_FIRST, 1'b1);
    for (int i = 4; i >= 0; i--)
      send_request(i, SET_SECOND, i == 0);
    send_request(-7, SET_SECOND, 1'b0);
    send_request(9, SET_FIRST, 1'b0);
    send_request(2, SET_SECOND, 1'b0);
    send_request(-3, SET_FIRST, 1'b1);
    send_request(8, SET_SECOND, 1'b1);
    send_request(0, SET_FIRST, 1'b0);
    send_request(0, SET_FIRST, 1'b0);
    send_request(-1, SET_FIRST, 1'b1);
    send_request(VALUE_MAX, SET_SECOND, 1'b0);
    send_request(VALUE_MAX, SET_SECOND, 1'b1);
  endtask

  // Fills each set to the brim. The first set gets one more value that carries the last
  // flag, so that value is dropped but still ends the set. The second set gets exactly
  // CAPACITY values and then two extra, with the last flag on the final extra.
  task automatic test_set_overflow();
    for (int i = 0; i < CAPACITY; i++)
      send_request(rand_value(), SET_FIRST, 1'b0);
    send_request(rand_value(), SET_FIRST, 1'b1);
    for (int i = 0; i < CAPACITY + 2; i++)
      send_request(rand_value(), SET_SECOND, i == CAPACITY + 1);
  endtask

  // Random values in randomly sized sets, with the two sets interleaved at random. A set
  // still open at the end carries into the next call.
  task automatic test_random_sets(input int n_requests);
    int left[2];
    int sid;
    left[0] = pick_set_size();
    left[1] = pick_set_size();
    for (int i = 0; i < n_requests; i++) begin
      sid = $urandom_range(1);
      send_request(rand_value(), 1'(sid), left[sid] == 1);
      left[sid]--;
      if (left[sid] == 0)
        left[sid] = pick_set_size();
    end
  endtask

  // Holds the result side off for a long stretch while short sets keep arriving, so a
  // finished result stays stuck in the block and the request side backs up behind it.
  task automatic test_output_hold();
    hold_req <= 1'b1;
    for (int i = 0; i < 40; i++)
      send_request(rand_value(), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The sender is mostly busy and the receiver mostly stalled.
    send_idle_pct = 13;
    recv_stall_pct = 77;
    test_directed_cases();
    test_set_overflow();
    test_random_sets(500);

    // Swap the roles: the sender is mostly idle and the receiver mostly ready.
    send_idle_pct = 77;
    recv_stall_pct = 13;
    test_random_sets(500);
    test_output_hold();

    // Neither side idles.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_sets(450);

    // Let every expected result come out, then watch a while for anything extra.
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("two_set_median_average_top: match");
    else
      $display("two_set_median_average_top: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tsma_pkg.sv
hw/rtl/two_set_median_average_top.sv
sim/two_set_median_average_top_tb.sv
